// ===== rtl/core/lcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_pkg: shared types and constants of the line command parser
// Command codes, the result struct passed from the parse core to the top
// level, and the characters the parser recognizes.
// ----------------------------------------------------------------------------
package lcp_pkg;

  // Command codes carried on the result channel
  typedef enum logic [1:0] {
    CMD_INVALID = 2'd0,
    CMD_ON      = 2'd1,
    CMD_OFF     = 2'd2,
    CMD_KEEP    = 2'd3
  } cmd_t;

  // One result from the parse core for the current byte
  typedef struct packed {
    logic        emit;
    cmd_t        cmd;
    logic [31:0] minutes;
  } lcp_result_t;

  // Characters of interest
  localparam logic [7:0] CHR_ONE   = 8'h31;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_VT    = 8'h0B;
  localparam logic [7:0] CHR_FF    = 8'h0C;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;

  // Length of the "KEEP " prefix
  localparam logic [2:0] PREFIX_LEN = 3'd5;

  // Character of the "KEEP " prefix at a given position
  function automatic logic [7:0] keep_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h4B; // K
      3'd1:    c = 8'h45; // E
      3'd2:    c = 8'h45; // E
      3'd3:    c = 8'h50; // P
      3'd4:    c = 8'h20; // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/lcp_parse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_parse_core: per-byte line parser state and update logic
// Holds the running line state (length, prefix match, number reader) and
// computes the result caused by the presented byte in a single pass.
// ----------------------------------------------------------------------------
module lcp_parse_core #(
  parameter int LINE_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [7:0]           rx_byte,
  output lcp_pkg::lcp_result_t res
);

  localparam int LEN_W = $clog2(LINE_BYTES);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BYTES - 1);

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_STOP   = 2'd2
  } num_phase_t;

  logic [LEN_W-1:0] line_len_r,   line_len_nxt;
  logic [2:0]       prefix_r,     prefix_nxt;
  logic             failed_r,     failed_nxt;
  num_phase_t       phase_r,      phase_nxt;
  logic             negative_r,   negative_nxt;
  logic [31:0]      acc_r,        acc_nxt;
  logic             ended_r,      ended_nxt;

  logic        is_digit;
  logic        is_blank;
  logic [31:0] digit_val;
  logic [31:0] acc_times10;
  logic [31:0] value;

  // Character classes and number arithmetic
  assign is_digit    = (rx_byte >= lcp_pkg::CHR_ZERO) && (rx_byte <= lcp_pkg::CHR_NINE);
  assign is_blank    = (rx_byte == lcp_pkg::CHR_SPACE) || (rx_byte == lcp_pkg::CHR_TAB) ||
                       (rx_byte == lcp_pkg::CHR_VT)    || (rx_byte == lcp_pkg::CHR_FF);
  assign digit_val   = {28'd0, rx_byte[3:0]};
  assign acc_times10 = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0};
  assign value       = negative_r ? (32'd0 - acc_r) : acc_r;

  // Next state and result for the presented byte
  always_comb begin
    line_len_nxt = line_len_r;
    prefix_nxt   = prefix_r;
    failed_nxt   = failed_r;
    phase_nxt    = phase_r;
    negative_nxt = negative_r;
    acc_nxt      = acc_r;
    ended_nxt    = ended_r;
    res          = '0;

    if ((rx_byte == lcp_pkg::CHR_ONE) || (rx_byte == lcp_pkg::CHR_ZERO)) begin
      // immediate on/off, line restarts
      res.emit     = 1'b1;
      res.cmd      = (rx_byte == lcp_pkg::CHR_ONE) ? lcp_pkg::CMD_ON : lcp_pkg::CMD_OFF;
      line_len_nxt = '0;
      prefix_nxt   = '0;
      failed_nxt   = 1'b0;
      phase_nxt    = NUM_SKIP;
      negative_nxt = 1'b0;
      acc_nxt      = '0;
      ended_nxt    = 1'b0;
    end else if ((rx_byte == lcp_pkg::CHR_CR) || (rx_byte == lcp_pkg::CHR_LF)) begin
      // end of line: emit only for a non-empty line
      if (line_len_r != '0) begin
        res.emit = 1'b1;
        if (!failed_r && (prefix_r == lcp_pkg::PREFIX_LEN) && (value != 32'd0)) begin
          res.cmd     = lcp_pkg::CMD_KEEP;
          res.minutes = value;
        end else begin
          res.cmd     = lcp_pkg::CMD_INVALID;
        end
      end
      line_len_nxt = '0;
      prefix_nxt   = '0;
      failed_nxt   = 1'b0;
      phase_nxt    = NUM_SKIP;
      negative_nxt = 1'b0;
      acc_nxt      = '0;
      ended_nxt    = 1'b0;
    end else if (line_len_r >= LEN_LIMIT) begin
      // overlong line is dropped
      line_len_nxt = '0;
      prefix_nxt   = '0;
      failed_nxt   = 1'b0;
      phase_nxt    = NUM_SKIP;
      negative_nxt = 1'b0;
      acc_nxt      = '0;
      ended_nxt    = 1'b0;
    end else begin
      if (!ended_r) begin
        if (rx_byte == lcp_pkg::CHR_NUL) begin
          ended_nxt = 1'b1;
          if (prefix_r < lcp_pkg::PREFIX_LEN) begin
            failed_nxt = 1'b1;
          end
        end else if (!failed_r) begin
          if (prefix_r < lcp_pkg::PREFIX_LEN) begin
            if (rx_byte == lcp_pkg::keep_char(prefix_r)) begin
              prefix_nxt = prefix_r + 3'd1;
            end else begin
              failed_nxt = 1'b1;
            end
          end else begin
            // atoi-style number reader
            unique case (phase_r)
              NUM_SKIP: begin
                if (!is_blank) begin
                  if (rx_byte == lcp_pkg::CHR_PLUS) begin
                    phase_nxt = NUM_DIGITS;
                  end else if (rx_byte == lcp_pkg::CHR_MINUS) begin
                    negative_nxt = 1'b1;
                    phase_nxt    = NUM_DIGITS;
                  end else if (is_digit) begin
                    acc_nxt   = digit_val;
                    phase_nxt = NUM_DIGITS;
                  end else begin
                    phase_nxt = NUM_STOP;
                  end
                end
              end
              NUM_DIGITS: begin
                if (is_digit) begin
                  acc_nxt = acc_times10 + digit_val;
                end else begin
                  phase_nxt = NUM_STOP;
                end
              end
              default: begin
                phase_nxt = phase_r;
              end
            endcase
          end
        end
      end
      line_len_nxt = line_len_r + LEN_W'(1);
    end
  end

  // State registers, updated once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= '0;
      prefix_r   <= '0;
      failed_r   <= 1'b0;
      phase_r    <= NUM_SKIP;
      negative_r <= 1'b0;
      acc_r      <= '0;
      ended_r    <= 1'b0;
    end else if (step_en) begin
      line_len_r <= line_len_nxt;
      prefix_r   <= prefix_nxt;
      failed_r   <= failed_nxt;
      phase_r    <= phase_nxt;
      negative_r <= negative_nxt;
      acc_r      <= acc_nxt;
      ended_r    <= ended_nxt;
    end
  end

`ifndef SYNTHESIS
  a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
    prefix_r <= lcp_pkg::PREFIX_LEN)
    else $error("prefix progress beyond KEEP text");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= LEN_LIMIT)
    else $error("line length beyond limit");

  a_keep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.emit && (res.cmd == lcp_pkg::CMD_KEEP)) |-> (res.minutes != 32'd0))
    else $error("keep-on result with zero minutes");

  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.emit && (res.cmd != lcp_pkg::CMD_KEEP)) |-> (res.minutes == 32'd0))
    else $error("non keep-on result with nonzero minutes");
`endif

endmodule

// ===== rtl/core/line_command_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_command_parser: serial text line to command decoder
// Turns received bytes into ON, OFF, KEEP_ON and INVALID commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) takes one received byte
//   per beat. Output channel (out_valid / out_stall / out_command /
//   out_minutes) delivers at most one command per input byte: '1' and '0'
//   give ON and OFF at once, CR or LF closes a non-empty line with KEEP_ON
//   (minutes != 0) or INVALID. Other bytes give no result.
//   Path: a byte is registered in the input register on acceptance, and its
//   command is then registered in the output register once that register
//   is free to take it.
//   Throughput: one byte per cycle while out_stall is low; the whole per-byte
//   update is a single pass between the input and the output register.
//   Stall: out_stall holds the output beat; the input register keeps
//   filling until its byte must wait for the output slot, then in_stall
//   rises. No beat is lost or repeated.
//   Reset (rst_n low, synchronous): both registers empty, line state
//   cleared to an empty line.
// ----------------------------------------------------------------------------
module line_command_parser #(
  parameter int LINE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_command,
  output logic [31:0] out_minutes
);

  logic        stage_valid_r, stage_valid_nxt;
  logic [7:0]  stage_byte_r;
  logic        out_valid_r,   out_valid_nxt;
  logic [1:0]  out_cmd_r;
  logic [31:0] out_min_r;
  logic        out_free;
  logic        advance;
  logic        in_take;
  lcp_pkg::lcp_result_t res;

  // Handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = stage_valid_r && out_free;
  assign in_stall = stage_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign stage_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : stage_valid_r);
  assign out_valid_nxt   = out_free ? (advance && res.emit) : out_valid_r;

  // Parser state and per-byte logic
  lcp_parse_core #(
    .LINE_BYTES(LINE_BYTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (stage_byte_r),
    .res     (res)
  );

  // Input and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    if (in_take) begin
      stage_byte_r <= in_rx_byte;
    end
    if (out_free) begin
      out_cmd_r <= res.cmd;
      out_min_r <= res.minutes;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_command = out_cmd_r;
  assign out_minutes = out_min_r;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stage_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked output");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.emit) |=> out_valid_r)
    else $error("emitted command did not reach output register");

  a_silent_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_free && !(advance && res.emit)) |=> !out_valid_r)
    else $error("output valid without an emitted command");
`endif

endmodule

// ===== tb/lcp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_checker: command predictor and result checker for line_command_parser
// Watches both channels of the parser. Every byte taken on the input channel
// is run through an independent line parser, and the command it causes, if
// any, is queued. Every beat taken on the output channel is compared field by
// field with the oldest queued command. Failures and the number of commands
// still in flight are handed to the testbench top.
// ----------------------------------------------------------------------------
module lcp_checker #(
  parameter int LINE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_command,
  input  logic [31:0] out_minutes,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    lcp_pkg::cmd_t command;
    logic [31:0]   minutes;
  } command_beat_t;

  typedef enum logic [1:0] {
    NUM_BLANKS = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_phase_t;

  localparam logic [7:0] KEEP_TEXT [0:4] = '{8'h4B, 8'h45, 8'h45, 8'h50, 8'h20};

  // Commands predicted but not yet delivered, oldest first
  command_beat_t pending_commands[$];

  // Line state of the predictor
  int unsigned line_len;
  logic [2:0]  prefix_matched;
  logic        prefix_bad;
  num_phase_t  num_phase;
  logic        num_neg;
  logic [31:0] minutes_acc;
  logic        text_ended;

  task automatic clear_line();
    line_len       = 0;
    prefix_matched = '0;
    prefix_bad     = 1'b0;
    num_phase      = NUM_BLANKS;
    num_neg        = 1'b0;
    minutes_acc    = '0;
    text_ended     = 1'b0;
  endtask

  // Advance the line state by one byte; queue the command it causes
  task automatic parse_byte(input logic [7:0] b);
    command_beat_t beat;
    logic          emits;
    logic          is_digit;
    logic [31:0]   value;
    emits    = 1'b0;
    is_digit = (b >= lcp_pkg::CHR_ZERO) && (b <= lcp_pkg::CHR_NINE);
    beat     = '{command: lcp_pkg::CMD_INVALID, minutes: '0};
    if (b == lcp_pkg::CHR_ONE || b == lcp_pkg::CHR_ZERO) begin
      // ON / OFF anywhere, line restarts
      clear_line();
      emits        = 1'b1;
      beat.command = (b == lcp_pkg::CHR_ONE) ? lcp_pkg::CMD_ON : lcp_pkg::CMD_OFF;
    end else if (b == lcp_pkg::CHR_CR || b == lcp_pkg::CHR_LF) begin
      // end of line; empty lines give nothing
      if (line_len != 0) begin
        emits = 1'b1;
        value = num_neg ? -minutes_acc : minutes_acc;
        if (!prefix_bad && prefix_matched == lcp_pkg::PREFIX_LEN && value != 0) begin
          beat.command = lcp_pkg::CMD_KEEP;
          beat.minutes = value;
        end
      end
      clear_line();
    end else if (line_len >= LINE_BYTES - 1) begin
      // overlong line is dropped silently
      clear_line();
    end else begin
      if (!text_ended) begin
        if (b == lcp_pkg::CHR_NUL) begin
          text_ended = 1'b1;
          if (prefix_matched < lcp_pkg::PREFIX_LEN) prefix_bad = 1'b1;
        end else if (!prefix_bad) begin
          if (prefix_matched < lcp_pkg::PREFIX_LEN) begin
            if (b == KEEP_TEXT[prefix_matched]) prefix_matched = prefix_matched + 3'd1;
            else prefix_bad = 1'b1;
          end else begin
            // number after the prefix: blanks, sign, digits
            case (num_phase)
              NUM_BLANKS: begin
                if (b inside {lcp_pkg::CHR_SPACE, lcp_pkg::CHR_TAB,
                              lcp_pkg::CHR_VT, lcp_pkg::CHR_FF}) begin
                end else if (b == lcp_pkg::CHR_PLUS) begin
                  num_phase = NUM_DIGITS;
                end else if (b == lcp_pkg::CHR_MINUS) begin
                  num_neg   = 1'b1;
                  num_phase = NUM_DIGITS;
                end else if (is_digit) begin
                  minutes_acc = 32'(b - lcp_pkg::CHR_ZERO);
                  num_phase   = NUM_DIGITS;
                end else begin
                  num_phase = NUM_DONE;
                end
              end
              NUM_DIGITS: begin
                if (is_digit)
                  minutes_acc = minutes_acc * 32'd10 + 32'(b - lcp_pkg::CHR_ZERO);
                else num_phase = NUM_DONE;
              end
              default: ;
            endcase
          end
        end
      end
      line_len++;
    end
    if (emits) pending_commands.push_back(beat);
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
    clear_line();
  end

  // Observe both channels at each rising edge
  always @(posedge clk) begin
    command_beat_t want;
    if (!rst_n) begin
      clear_line();
      pending_commands.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_commands.size() == 0) begin
          $error("unexpected result beat: command %0d minutes %0d",
                 out_command, out_minutes);
          fail_count++;
        end else begin
          want = pending_commands.pop_front();
          if (out_command !== want.command) begin
            $error("command mismatch: expected %0d (%s), actual %0d",
                   want.command, want.command.name(), out_command);
            fail_count++;
          end
          if (out_minutes !== want.minutes) begin
            $error("minutes mismatch: expected %0d, actual %0d",
                   want.minutes, out_minutes);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) parse_byte(in_rx_byte);
    end
    outstanding = pending_commands.size();
  end

endmodule

// ===== tb/line_command_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_command_parser_test: stimulus and verdict for line_command_parser
// Sends a short directed set of lines, then random lines (well formed
// KEEP commands, plus damaged prefixes, lines near the length limit, NUL
// bytes, ON/OFF bytes and noise) through several idle and stall patterns,
// including a long output hold-off and a full drain. Checking is done by
// lcp_checker.
// ----------------------------------------------------------------------------
module line_command_parser_test;

  localparam int LINE_BYTES      = 32;
  localparam int PHASE_BYTES     = 175;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam logic [7:0] BLANKS [0:3] = '{lcp_pkg::CHR_SPACE, lcp_pkg::CHR_TAB,
                                          lcp_pkg::CHR_VT, lcp_pkg::CHR_FF};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_command;
  logic [31:0] out_minutes;

  int fail_count;
  int outstanding;
  int bytes_sent;
  int send_idle_pct;
  int stall_pct;
  bit hold_off_req;

  line_command_parser #(.LINE_BYTES(LINE_BYTES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_command(out_command),
    .out_minutes(out_minutes)
  );

  lcp_checker #(.LINE_BYTES(LINE_BYTES)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_command(out_command),
    .out_minutes(out_minutes),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("line_command_parser_test NOT OK");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // One input beat, with optional idle cycles ahead of it
  task automatic send_beat(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_beat(s[i]);
  endtask

  // Stop sending and wait until every predicted command has been delivered
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  // Any byte that neither ends a line nor gives ON/OFF
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == lcp_pkg::CHR_ONE || b == lcp_pkg::CHR_ZERO ||
           b == lcp_pkg::CHR_CR || b == lcp_pkg::CHR_LF);
    return b;
  endfunction

  task automatic send_random_line();
    logic [7:0] line_bytes[$];
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 55) begin
      // KEEP line; some with a damaged prefix byte
      line_bytes = '{8'h4B, 8'h45, 8'h45, 8'h50, lcp_pkg::CHR_SPACE};
      if (kind >= 45) line_bytes[$urandom_range(4)] = plain_byte();
      repeat ($urandom_range(2)) line_bytes.push_back(BLANKS[$urandom_range(3)]);
      case ($urandom_range(3))
        0: line_bytes.push_back(lcp_pkg::CHR_PLUS);
        1: line_bytes.push_back(lcp_pkg::CHR_MINUS);
        default: ;
      endcase
      // long numbers wrap; a stray 0 or 1 digit restarts the line
      n = ($urandom_range(9) == 0) ? $urandom_range(11, 14) : $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(19) == 0) line_bytes.push_back(8'($urandom_range(48, 57)));
        else line_bytes.push_back(8'($urandom_range(50, 57)));
      end
      repeat ($urandom_range(2)) line_bytes.push_back(plain_byte());
    end else if (kind < 65) begin
      // line around the length limit
      line_bytes = '{8'h4B, 8'h45, 8'h45, 8'h50, lcp_pkg::CHR_SPACE, 8'h37};
      n = $urandom_range(LINE_BYTES - 4, LINE_BYTES + 3);
      while (line_bytes.size() < n) line_bytes.push_back(plain_byte());
    end else if (kind < 72) begin
      // NUL somewhere in a KEEP line
      line_bytes = '{8'h4B, 8'h45, 8'h45, 8'h50, lcp_pkg::CHR_SPACE, 8'h36};
      line_bytes.insert($urandom_range(6), lcp_pkg::CHR_NUL);
    end else if (kind < 80) begin
      line_bytes.push_back($urandom_range(1) ? lcp_pkg::CHR_ONE : lcp_pkg::CHR_ZERO);
    end else begin
      repeat ($urandom_range(8)) line_bytes.push_back(8'($urandom_range(255)));
    end
    // terminator; ON/OFF bytes stand alone and noise sometimes runs on
    if (kind < 72 || (kind >= 80 && $urandom_range(2) != 0))
      line_bytes.push_back($urandom_range(1) ? lcp_pkg::CHR_CR : lcp_pkg::CHR_LF);
    foreach (line_bytes[i]) send_beat(line_bytes[i]);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_chance, input int count);
    int target;
    send_idle_pct = idle_pct;
    stall_pct     = stall_chance;
    target        = bytes_sent + count;
    while (bytes_sent < target) send_random_line();
  endtask

  // Stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_rx_byte    = 8'h00;
    bytes_sent    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off_req  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ON, OFF, empty line, KEEP, negative after blank, 0xFF, NUL
    send_beat(lcp_pkg::CHR_ONE);
    send_beat(lcp_pkg::CHR_ZERO);
    send_beat(lcp_pkg::CHR_CR);
    send_text("KEEP 9");
    send_beat(lcp_pkg::CHR_LF);
    send_text("KEEP ");
    send_beat(lcp_pkg::CHR_TAB);
    send_text("-2");
    send_beat(lcp_pkg::CHR_CR);
    send_beat(8'hFF);
    send_beat(lcp_pkg::CHR_LF);
    send_text("KEEP");
    send_beat(lcp_pkg::CHR_NUL);
    send_text(" 5");
    send_beat(lcp_pkg::CHR_LF);

    // back pressure: long output hold-off while bytes keep coming
    hold_off_req = 1'b1;
    repeat (24) send_beat($urandom_range(1) ? lcp_pkg::CHR_ONE : lcp_pkg::CHR_ZERO);
    drain();

    run_phase(0, 0, PHASE_BYTES);
    run_phase(81, 0, PHASE_BYTES);
    run_phase(0, 81, PHASE_BYTES);
    run_phase(32, 32, PHASE_BYTES);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("line_command_parser_test OK");
    end else begin
      $display("line_command_parser_test NOT OK");
    end
    $finish;
  end

endmodule
